### src/isr_pkg.sv
// Shared types and codes for the ISO SDU reassembler.
// No dependencies; used by isr_core and iso_sdu_reassembler.
package isr_pkg;

  // packet boundary codes
  localparam logic [1:0] PB_FIRST    = 2'd0;
  localparam logic [1:0] PB_CONT     = 2'd1;
  localparam logic [1:0] PB_COMPLETE = 2'd2;
  localparam logic [1:0] PB_LAST     = 2'd3;

  // packet end report codes
  localparam logic [1:0] EV_MID     = 2'd0;
  localparam logic [1:0] EV_PENDING = 2'd1;
  localparam logic [1:0] EV_DONE    = 2'd2;
  localparam logic [1:0] EV_DROP    = 2'd3;

  localparam logic [3:0]  HDR_LEN_TS    = 4'd8;
  localparam logic [3:0]  HDR_LEN_NO_TS = 4'd4;
  localparam logic [12:0] COUNT_MAX     = 13'd8191;

  typedef struct packed {
    logic [1:0] pb_flag;
    logic       ts_flag;
    logic [7:0] load_byte;
    logic       byte_valid;
    logic       packet_end;
  } item_t;

  typedef struct packed {
    logic        write_enable;
    logic [11:0] write_offset;
    logic [7:0]  write_byte;
    logic [1:0]  event_res;
    logic [15:0] sdu_sequence;
    logic [31:0] sdu_timestamp;
    logic [1:0]  sdu_packet_status;
    logic [11:0] sdu_length;
  } result_t;

endpackage

### src/isr_core.sv
// Reassembly state and per-byte header parse, write strobe and packet end decision.
// Depends on isr_pkg for item_t, result_t and the boundary and event codes.
module isr_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  isr_pkg::item_t   item,
  output isr_pkg::result_t res
);
  import isr_pkg::*;

  logic        packet_open, packet_open_next;
  logic [1:0]  packet_kind, packet_kind_next;
  logic        packet_has_ts, packet_has_ts_next;
  logic [3:0]  header_index, header_index_next;
  logic [12:0] packet_data_count, packet_data_count_next;
  logic [15:0] length_word, length_word_next;
  logic        sdu_open, sdu_open_next;
  logic [11:0] sdu_total_length, sdu_total_length_next;
  logic [11:0] sdu_filled, sdu_filled_next;
  logic [15:0] sdu_seq, sdu_seq_next;
  logic [31:0] sdu_time, sdu_time_next;
  logic [1:0]  sdu_status, sdu_status_next;

  always_comb begin
    logic        clr;
    logic        headed;
    logic [3:0]  hlen;
    logic [3:0]  pos;
    logic [13:0] off;
    logic        ok;
    logic [12:0] n;
    logic [12:0] room;
    logic [12:0] filled_sum;
    logic        done;
    logic        drop;

    // open a packet: latch its kind, reset per-packet counters, clear the SDU on a first or complete packet
    packet_open_next  = packet_open;
    packet_kind_next  = packet_kind;
    packet_has_ts_next = packet_has_ts;
    header_index_next = header_index;
    packet_data_count_next = packet_data_count;
    length_word_next  = length_word;
    sdu_open_next     = sdu_open;
    sdu_total_length_next = sdu_total_length;
    sdu_filled_next   = sdu_filled;
    sdu_seq_next      = sdu_seq;
    sdu_time_next     = sdu_time;
    sdu_status_next   = sdu_status;
    res = '0;

    clr = (item.pb_flag == PB_FIRST) || (item.pb_flag == PB_COMPLETE);
    if (!packet_open) begin
      packet_open_next   = 1'b1;
      packet_kind_next   = item.pb_flag;
      packet_has_ts_next = item.ts_flag;
      header_index_next  = '0;
      packet_data_count_next = '0;
      if (clr) begin
        sdu_open_next = 1'b0;
        sdu_total_length_next = '0;
        sdu_filled_next = '0;
        sdu_seq_next = '0;
        sdu_time_next = '0;
        sdu_status_next = '0;
        length_word_next = '0;
      end
    end

    headed = (packet_kind_next == PB_FIRST) || (packet_kind_next == PB_COMPLETE);
    hlen = headed ? (packet_has_ts_next ? HDR_LEN_TS : HDR_LEN_NO_TS) : 4'd0;
    pos = packet_has_ts_next ? header_index_next : header_index_next + 4'd4;
    off = headed ? {1'b0, packet_data_count_next}
                 : 14'(sdu_filled_next) + 14'(packet_data_count_next);
    ok = headed ? (off < 14'(sdu_total_length_next))
                : (sdu_open_next && (off < 14'(sdu_total_length_next)));

    if (item.byte_valid) begin
      if (header_index_next < hlen) begin
        case (pos)
          4'd0: sdu_time_next[7:0]   = sdu_time_next[7:0]   | item.load_byte;
          4'd1: sdu_time_next[15:8]  = sdu_time_next[15:8]  | item.load_byte;
          4'd2: sdu_time_next[23:16] = sdu_time_next[23:16] | item.load_byte;
          4'd3: sdu_time_next[31:24] = sdu_time_next[31:24] | item.load_byte;
          4'd4: sdu_seq_next[7:0]    = sdu_seq_next[7:0]    | item.load_byte;
          4'd5: sdu_seq_next[15:8]   = sdu_seq_next[15:8]   | item.load_byte;
          4'd6: length_word_next[7:0]  = length_word_next[7:0]  | item.load_byte;
          4'd7: length_word_next[15:8] = length_word_next[15:8] | item.load_byte;
          default: ;
        endcase
        if (pos == 4'd6 || pos == 4'd7) begin
          sdu_total_length_next = length_word_next[11:0];
          sdu_status_next = length_word_next[15:14];
        end
        header_index_next = header_index_next + 4'd1;
      end else begin
        if (ok) begin
          res.write_enable = 1'b1;
          res.write_offset = off[11:0];
          res.write_byte   = item.load_byte;
        end
        if (packet_data_count_next < COUNT_MAX) begin
          packet_data_count_next = packet_data_count_next + 13'd1;
        end
      end
    end

    n = packet_data_count_next;
    room = 13'(sdu_total_length_next - sdu_filled_next);
    filled_sum = 13'(sdu_filled_next) + n;
    done = 1'b0;
    drop = 1'b0;

    if (item.packet_end) begin
      packet_open_next = 1'b0;
      if (headed && (header_index_next < hlen)) begin
        drop = 1'b1;
      end else if (packet_kind_next == PB_COMPLETE) begin
        if (n != 13'(sdu_total_length_next)) drop = 1'b1;
        else done = 1'b1;
      end else if (packet_kind_next == PB_FIRST) begin
        if (sdu_total_length_next == '0 || n >= 13'(sdu_total_length_next)) begin
          drop = 1'b1;
        end else begin
          sdu_open_next = 1'b1;
          sdu_filled_next = n[11:0];
          res.event_res = EV_PENDING;
        end
      end else begin
        if (!sdu_open_next || n > room) begin
          drop = 1'b1;
        end else begin
          sdu_filled_next = filled_sum[11:0];
          if (packet_kind_next == PB_LAST) begin
            if (filled_sum[11:0] != sdu_total_length_next) drop = 1'b1;
            else done = 1'b1;
          end else begin
            res.event_res = EV_PENDING;
          end
        end
      end

      if (done) begin
        res.event_res = EV_DONE;
        res.sdu_sequence = sdu_seq_next;
        res.sdu_timestamp = sdu_time_next;
        res.sdu_packet_status = sdu_status_next;
        res.sdu_length = sdu_total_length_next;
      end
      if (drop) res.event_res = EV_DROP;
      // finished or dropped: release the SDU
      if (done || drop) begin
        sdu_open_next = 1'b0;
        sdu_total_length_next = '0;
        sdu_filled_next = '0;
        sdu_seq_next = '0;
        sdu_time_next = '0;
        sdu_status_next = '0;
        length_word_next = '0;
      end
      header_index_next = '0;
      packet_data_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open <= 1'b0;
      packet_kind <= '0;
      packet_has_ts <= 1'b0;
      header_index <= '0;
      packet_data_count <= '0;
      length_word <= '0;
      sdu_open <= 1'b0;
      sdu_total_length <= '0;
      sdu_filled <= '0;
      sdu_seq <= '0;
      sdu_time <= '0;
      sdu_status <= '0;
    end else if (step) begin
      packet_open <= packet_open_next;
      packet_kind <= packet_kind_next;
      packet_has_ts <= packet_has_ts_next;
      header_index <= header_index_next;
      packet_data_count <= packet_data_count_next;
      length_word <= length_word_next;
      sdu_open <= sdu_open_next;
      sdu_total_length <= sdu_total_length_next;
      sdu_filled <= sdu_filled_next;
      sdu_seq <= sdu_seq_next;
      sdu_time <= sdu_time_next;
      sdu_status <= sdu_status_next;
    end
  end

endmodule

### src/iso_sdu_reassembler.sv
// HCI ISO receive-side SDU reassembler: input register, isr_core, result register.
// Depends on isr_pkg and isr_core.
//
// Takes one ISO data load byte per transaction and gives exactly one result
// per transaction: a write strobe with SDU offset for payload bytes and, on
// the packet's last item, a progress, SDU complete (with sequence, timestamp,
// status and length) or drop report. Throughput is one item per clock while
// the result side accepts; an accepted item waits in the input register, and
// the reassembly state update feeds its result into the result register.
// Ready follows the result side combinationally, so both sides may stream
// without bubbles and either may stall at any time.
module iso_sdu_reassembler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  pb_flag,
  input  logic        ts_flag,
  input  logic [7:0]  load_byte,
  input  logic        byte_valid,
  input  logic        packet_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_enable,
  output logic [11:0] write_offset,
  output logic [7:0]  write_byte,
  output logic [1:0]  event_res,
  output logic [15:0] sdu_sequence,
  output logic [31:0] sdu_timestamp,
  output logic [1:0]  sdu_packet_status,
  output logic [11:0] sdu_length
);
  import isr_pkg::*;

  item_t   in_q;
  logic    in_q_valid;
  result_t core_res;
  result_t out_q;
  logic    advance;
  logic    take;

  assign advance  = !out_valid || out_ready;
  assign take     = in_q_valid && advance;
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= '{pb_flag: pb_flag, ts_flag: ts_flag, load_byte: load_byte,
                byte_valid: byte_valid, packet_end: packet_end};
    end
  end

  isr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .item (in_q),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (take) begin
      out_q <= core_res;
    end
  end

  assign write_enable      = out_q.write_enable;
  assign write_offset      = out_q.write_offset;
  assign write_byte        = out_q.write_byte;
  assign event_res         = out_q.event_res;
  assign sdu_sequence      = out_q.sdu_sequence;
  assign sdu_timestamp     = out_q.sdu_timestamp;
  assign sdu_packet_status = out_q.sdu_packet_status;
  assign sdu_length        = out_q.sdu_length;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for iso_sdu_reassembler: feeds HCI ISO load bytes,
// predicts every write strobe and packet-end report, and checks them in order.
// Depends on isr_pkg and the iso_sdu_reassembler RTL.
module tb_top;
  import isr_pkg::*;

  localparam int IDLE_LIMIT   = 600;
  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_TAIL    = 60;

  typedef struct {
    item_t it;
    bit    hold;
  } load_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [1:0]  pb_flag    = PB_FIRST;
  logic        ts_flag    = 1'b0;
  logic [7:0]  load_byte  = '0;
  logic        byte_valid = 1'b0;
  logic        packet_end = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        write_enable;
  logic [11:0] write_offset;
  logic [7:0]  write_byte;
  logic [1:0]  event_res;
  logic [15:0] sdu_sequence;
  logic [31:0] sdu_timestamp;
  logic [1:0]  sdu_packet_status;
  logic [11:0] sdu_length;

  iso_sdu_reassembler DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pb_flag(pb_flag), .ts_flag(ts_flag), .load_byte(load_byte),
    .byte_valid(byte_valid), .packet_end(packet_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .write_enable(write_enable), .write_offset(write_offset), .write_byte(write_byte),
    .event_res(event_res), .sdu_sequence(sdu_sequence), .sdu_timestamp(sdu_timestamp),
    .sdu_packet_status(sdu_packet_status), .sdu_length(sdu_length)
  );

  always #5 clk = ~clk;

  // stimulus and expected reports
  load_t   load_q [$];
  result_t awaited_reports [$];
  int      queued;
  int      stray_pct;

  // predicted reassembly state
  logic        pkt_active;
  logic [1:0]  pkt_pb;
  logic        pkt_ts;
  logic [3:0]  hdr_cnt;
  logic [12:0] data_cnt;
  logic [15:0] len_word;
  logic        sdu_active;
  logic [11:0] sdu_len;
  logic [11:0] sdu_fill;
  logic [15:0] sdu_seq_r;
  logic [31:0] sdu_ts_r;
  logic [1:0]  sdu_stat_r;

  int n_fed, n_checked, n_errors, n_writes, stall_cycles;
  int ev_seen [4];
  int send_gap, sink_gap;
  bit calm, quiet;
  item_t   cur_item;
  load_t   nx;
  result_t want;

  function automatic void drop_sdu();
    sdu_active = 1'b0;
    sdu_len    = '0;
    sdu_fill   = '0;
    sdu_seq_r  = '0;
    sdu_ts_r   = '0;
    sdu_stat_r = '0;
    len_word   = '0;
  endfunction

  function automatic result_t reassemble_byte(item_t it);
    result_t r;
    logic    headed, ok, finished;
    int      hdr_len, pos, off, n;
    r = '0;
    finished = 1'b0;
    if (!pkt_active) begin
      pkt_active = 1'b1;
      pkt_pb     = it.pb_flag;
      pkt_ts     = it.ts_flag;
      hdr_cnt    = '0;
      data_cnt   = '0;
      if (it.pb_flag == PB_FIRST || it.pb_flag == PB_COMPLETE) drop_sdu();
    end
    headed  = (pkt_pb == PB_FIRST || pkt_pb == PB_COMPLETE);
    hdr_len = headed ? (pkt_ts ? 8 : 4) : 0;

    if (it.byte_valid) begin
      if (int'(hdr_cnt) < hdr_len) begin
        // header order: timestamp (optional), sequence, length word; all little-endian
        pos = pkt_ts ? int'(hdr_cnt) : int'(hdr_cnt) + 4;
        if (pos < 4) begin
          sdu_ts_r = sdu_ts_r | (32'(it.load_byte) << (8 * pos));
        end else if (pos < 6) begin
          sdu_seq_r = sdu_seq_r | (16'(it.load_byte) << (8 * (pos - 4)));
        end else begin
          len_word   = len_word | (16'(it.load_byte) << (8 * (pos - 6)));
          sdu_len    = len_word[11:0];
          sdu_stat_r = len_word[15:14];
        end
        hdr_cnt = hdr_cnt + 4'd1;
      end else begin
        if (headed) begin
          off = int'(data_cnt);
          ok  = off < int'(sdu_len);
        end else begin
          off = int'(sdu_fill) + int'(data_cnt);
          ok  = sdu_active && off < int'(sdu_len);
        end
        if (ok) begin
          r.write_enable = 1'b1;
          r.write_offset = off[11:0];
          r.write_byte   = it.load_byte;
        end
        // saturate, never wrap
        if (data_cnt != COUNT_MAX) data_cnt = data_cnt + 13'd1;
      end
    end

    if (it.packet_end) begin
      n = int'(data_cnt);
      pkt_active = 1'b0;
      if (headed && int'(hdr_cnt) < hdr_len) begin
        r.event_res = EV_DROP;
      end else if (pkt_pb == PB_COMPLETE) begin
        if (n != int'(sdu_len)) r.event_res = EV_DROP;
        else finished = 1'b1;
      end else if (pkt_pb == PB_FIRST) begin
        if (sdu_len == 0 || n >= int'(sdu_len)) begin
          r.event_res = EV_DROP;
        end else begin
          sdu_active  = 1'b1;
          sdu_fill    = 12'(n);
          r.event_res = EV_PENDING;
        end
      end else if (!sdu_active || n > int'(sdu_len) - int'(sdu_fill)) begin
        r.event_res = EV_DROP;
      end else begin
        sdu_fill = sdu_fill + 12'(n);
        if (pkt_pb == PB_LAST) begin
          if (sdu_fill != sdu_len) r.event_res = EV_DROP;
          else finished = 1'b1;
        end else begin
          r.event_res = EV_PENDING;
        end
      end
      if (finished) begin
        r.event_res         = EV_DONE;
        r.sdu_sequence      = sdu_seq_r;
        r.sdu_timestamp     = sdu_ts_r;
        r.sdu_packet_status = sdu_stat_r;
        r.sdu_length        = sdu_len;
        drop_sdu();
      end
      if (r.event_res == EV_DROP) drop_sdu();
      hdr_cnt  = '0;
      data_cnt = '0;
    end
    return r;
  endfunction

  task automatic add_item(logic [1:0] pb, logic ts, logic [7:0] b, logic bv, logic last,
                          bit hold);
    load_t e;
    e.it.pb_flag    = pb;
    e.it.ts_flag    = ts;
    e.it.load_byte  = b;
    e.it.byte_valid = bv;
    e.it.packet_end = last;
    e.hold          = hold;
    load_q.push_back(e);
    queued++;
  endtask

  // One packet: the first hdr_n header bytes, data_n random bytes, stray blanks.
  task automatic add_packet(logic [1:0] pb, logic ts, int hdr_n, logic [31:0] stamp,
                            logic [15:0] seq, logic [15:0] lw, int data_n,
                            bit blank_end, bit hold);
    logic [7:0] hdr [$];
    logic [7:0] raw [$];
    logic [8:0] body [$];
    logic [1:0] pb_now;
    logic       ts_now;
    int         i;
    if (ts) hdr = '{stamp[7:0], stamp[15:8], stamp[23:16], stamp[31:24],
                    seq[7:0], seq[15:8], lw[7:0], lw[15:8]};
    else    hdr = '{seq[7:0], seq[15:8], lw[7:0], lw[15:8]};
    for (i = 0; i < hdr_n && i < hdr.size(); i++) raw.push_back(hdr[i]);
    repeat (data_n) raw.push_back(8'($urandom));
    foreach (raw[j]) begin
      if ($urandom_range(1, 100) <= stray_pct) body.push_back({1'b0, 8'($urandom)});
      body.push_back({1'b1, raw[j]});
    end
    if (blank_end || body.size() == 0) body.push_back({1'b0, 8'($urandom)});
    foreach (body[j]) begin
      pb_now = pb;
      ts_now = ts;
      // boundary and timestamp flags only count at packet start
      if (j != 0 && $urandom_range(1, 100) <= stray_pct) begin
        pb_now = 2'($urandom);
        ts_now = 1'($urandom);
      end
      add_item(pb_now, ts_now, body[j][7:0], body[j][8], j == body.size() - 1,
               hold && j == 0);
    end
  endtask

  // Fragmented SDU: first, continuations, last. flaw 0 is well formed;
  // 1 overflows the last, 2 shortens it or overflows it when none is left,
  // 3 cuts in with a new headed packet, 4 truncates the first header.
  task automatic add_sdu(int len, int flaw, bit hold);
    int          first, left, k;
    logic        ts;
    logic [15:0] lw;
    ts    = 1'($urandom);
    lw    = {2'($urandom), 2'($urandom), 12'(len)};
    first = $urandom_range(1, len - 1);
    if (flaw == 4) begin
      add_packet(PB_FIRST, ts, $urandom_range(0, ts ? 7 : 3), $urandom, 16'($urandom), lw,
                 0, 1'b0, hold);
      return;
    end
    add_packet(PB_FIRST, ts, 8, $urandom, 16'($urandom), lw, first, 1'b0, hold);
    left = len - first;
    while (left > 0 && $urandom_range(0, 2) != 0) begin
      k = $urandom_range(1, left);
      add_packet(PB_CONT, 1'($urandom), 0, '0, '0, '0, k, 1'($urandom_range(0, 5) == 0),
                 1'b0);
      left -= k;
    end
    if (flaw == 3)
      add_packet($urandom_range(0, 1) ? PB_FIRST : PB_COMPLETE, 1'b0, 4, '0,
                 16'($urandom), 16'($urandom_range(0, 6)), $urandom_range(0, 6), 1'b0, 1'b0);
    if (flaw == 1 || (flaw == 2 && left == 0)) left += $urandom_range(1, 3);
    else if (flaw == 2) left -= 1;
    add_packet(PB_LAST, 1'($urandom), 0, '0, '0, '0, left, 1'($urandom_range(0, 7) == 0),
               1'b0);
  endtask

  task automatic add_complete(int len, bit flawed, bit hold);
    int   n;
    logic ts;
    ts = 1'($urandom);
    n  = len;
    if (flawed) n = (len > 0 && $urandom_range(0, 1)) ? $urandom_range(0, len - 1)
                                                      : len + $urandom_range(1, 3);
    add_packet(PB_COMPLETE, ts, 8, $urandom, 16'($urandom),
               {2'($urandom), 2'($urandom), 12'(len)}, n, 1'b0, hold);
  endtask

  task automatic add_noise();
    int cnt;
    cnt = $urandom_range(1, 6);
    for (int i = 0; i < cnt; i++)
      add_item(2'($urandom), 1'($urandom), 8'($urandom), $urandom_range(0, 6) != 0,
               (i == cnt - 1) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 3) == 0),
               1'b0);
  endtask

  task automatic cmp(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, exp_v, act_v);
      n_errors++;
    end
  endtask

  // driver: feeds load_q into the input channel
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_reports.push_back(reassemble_byte(cur_item));
        n_fed++;
      end
      calm = load_q.size() < CALM_TAIL;
      if ($urandom_range(0, 149) == 0) quiet = !quiet;
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (load_q.size() == 0 || (load_q[0].hold && awaited_reports.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (!calm && !quiet && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else begin
          nx = load_q.pop_front();
          cur_item = nx.it;
          pb_flag    <= nx.it.pb_flag;
          ts_flag    <= nx.it.ts_flag;
          load_byte  <= nx.it.load_byte;
          byte_valid <= nx.it.byte_valid;
          packet_end <= nx.it.packet_end;
          in_valid   <= 1'b1;
        end
      end
    end
  end

  // monitor: takes results, compares with the oldest prediction, stalls at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected result, event %0d offset %0d", $time, event_res,
                   write_offset);
          n_errors++;
        end else begin
          want = awaited_reports.pop_front();
          cmp("write_enable", 32'(want.write_enable), 32'(write_enable));
          cmp("write_offset", 32'(want.write_offset), 32'(write_offset));
          cmp("write_byte", 32'(want.write_byte), 32'(write_byte));
          cmp("event_res", 32'(want.event_res), 32'(event_res));
          cmp("sdu_sequence", 32'(want.sdu_sequence), 32'(sdu_sequence));
          cmp("sdu_timestamp", want.sdu_timestamp, sdu_timestamp);
          cmp("sdu_packet_status", 32'(want.sdu_packet_status), 32'(sdu_packet_status));
          cmp("sdu_length", 32'(want.sdu_length), 32'(sdu_length));
          ev_seen[want.event_res]++;
          if (want.write_enable) n_writes++;
          n_checked++;
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else if (!calm && !quiet && $urandom_range(0, 11) == 0) begin
        sink_gap = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: end the run when the channels stop moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles == IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               IDLE_LIMIT, awaited_reports.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int pick, big_n;
    bit big_done;
    pkt_active = 1'b0;
    pkt_pb     = '0;
    pkt_ts     = 1'b0;
    hdr_cnt    = '0;
    data_cnt   = '0;
    drop_sdu();
    big_done = 1'b0;
    big_n    = 0;
    stray_pct = 0;

    // directed: every boundary kind and report, extremes of the header fields
    add_packet(PB_COMPLETE, 1'b0, 4, '0, 16'hFFFF, 16'hC000, 0, 1'b0, 1'b0);  // empty SDU delivered
    add_packet(PB_FIRST, 1'b0, 4, '0, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);     // zero length first
    add_packet(PB_COMPLETE, 1'b1, 0, '0, '0, '0, 0, 1'b0, 1'b0);              // short header, no byte
    add_packet(PB_FIRST, 1'b0, 4, '0, 16'h1234, 16'h0001, 1, 1'b0, 1'b0);     // whole SDU in first
    add_packet(PB_FIRST, 1'b0, 4, '0, 16'h8001, 16'h7003, 1, 1'b1, 1'b0);     // pending, blank end
    add_packet(PB_CONT, 1'b1, 0, '0, '0, '0, 3, 1'b0, 1'b0);                  // overflow
    add_packet(PB_LAST, 1'b0, 0, '0, '0, '0, 1, 1'b0, 1'b0);                  // orphan
    add_packet(PB_FIRST, 1'b1, 8, 32'hFFFF_FFFF, 16'h00FF, 16'h4003, 1, 1'b0, 1'b0);
    add_packet(PB_LAST, 1'b1, 0, '0, '0, '0, 1, 1'b0, 1'b0);                  // short last

    // random: mostly well-formed SDUs, mixed with flawed ones and noise
    while (queued < RANDOM_ITEMS + 30 + big_n) begin
      stray_pct = ($urandom_range(0, 3) == 0) ? 8 : 0;
      pick = $urandom_range(0, 99);
      if (pick < 50)      add_sdu($urandom_range(2, 40), 0, $urandom_range(0, 39) == 0);
      else if (pick < 70) add_complete($urandom_range(0, 40), 1'b0, $urandom_range(0, 39) == 0);
      else if (pick < 80) add_sdu($urandom_range(2, 40), $urandom_range(1, 4), 1'b0);
      else if (pick < 88) add_complete($urandom_range(0, 40), 1'b1, 1'b0);
      else                add_noise();
      if (!big_done && queued > 230) begin
        // an SDU whose first byte waits for all earlier results, then the
        // largest length field in a complete packet that falls short of it
        big_n = queued;
        stray_pct = 0;
        add_sdu($urandom_range(2, 40), 0, 1'b1);
        add_packet(PB_COMPLETE, 1'b0, 4, '0, 16'h0BAD, 16'hCFFF, 5, 1'b0, 1'b0);
        big_n = queued - big_n;
        big_done = 1'b1;
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (n_fed < queued || awaited_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("fed %0d load bytes and checked %0d results, %0d of them buffer writes",
             n_fed, n_checked, n_writes);
    $display("reports: %0d mid, %0d pending, %0d SDUs done, %0d drops; %0d mismatches",
             ev_seen[EV_MID], ev_seen[EV_PENDING], ev_seen[EV_DONE], ev_seen[EV_DROP],
             n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
